// ===== hdl/disc_elastic_collision_macros.svh =====
// Assertion macros for the disc collision block.
// Used by modules that check their own logic; needs clk and rst_n in scope.
`ifndef DISC_ELASTIC_COLLISION_MACROS_SVH
`define DISC_ELASTIC_COLLISION_MACROS_SVH

// condition must never hold
`define DEC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define DEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dec_pkg.sv =====
// Shared types and constants of the disc collision block.
// No dependencies; imported by every module of the block.
`default_nettype none
package dec_pkg;

    localparam int POS_W   = 14;
    localparam int VEL_W   = 16;
    localparam int RAD_W   = 10;
    localparam int CFG_W   = 10;
    localparam int CFG_IDX_W = 1;
    localparam int DIFF_W  = POS_W + 1;
    localparam int DV_W    = VEL_W + 1;
    localparam int D2_W    = 2 * DIFF_W;
    localparam int RSUM_W  = RAD_W + 1;
    localparam int RSQ_W   = 2 * RSUM_W;
    localparam int DOT_W   = DV_W + DIFF_W + 1;
    localparam int PROD_W  = DOT_W + DIFF_W;
    localparam int NUM_W   = PROD_W + 1;
    localparam int DIV_W   = RSQ_W + 1;
    localparam int Q_W     = 18;
    localparam int REM_W   = DIV_W + 1;
    localparam int SUM_W   = Q_W + 2;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW = 3;
    localparam int CNT_W   = FIFO_AW + 1;
    localparam int VEL_MAX = 32767;
    localparam int VEL_MIN = -32768;

    localparam logic [RAD_W-1:0] DISC_RADIUS_RST = 10'd400;
    localparam logic [RAD_W-1:0] BALL_RADIUS_RST = 10'd240;

    localparam logic [CFG_IDX_W-1:0] REG_DISC_RADIUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BALL_RADIUS = 1'd1;

    typedef struct packed {
        logic [POS_W-1:0]        first_x;
        logic [POS_W-1:0]        first_y;
        logic signed [VEL_W-1:0] first_vx;
        logic signed [VEL_W-1:0] first_vy;
        logic [POS_W-1:0]        second_x;
        logic [POS_W-1:0]        second_y;
        logic signed [VEL_W-1:0] second_vx;
        logic signed [VEL_W-1:0] second_vy;
        logic                    second_is_ball;
    } req_t;

    typedef struct packed {
        logic                    contact;
        logic                    coincident;
        logic signed [VEL_W-1:0] new_first_vx;
        logic signed [VEL_W-1:0] new_first_vy;
        logic signed [VEL_W-1:0] new_second_vx;
        logic signed [VEL_W-1:0] new_second_vy;
    } rsp_t;

    typedef struct packed {
        logic                    contact;
        logic                    coincident;
        logic                    active;
        logic signed [VEL_W-1:0] vx1;
        logic signed [VEL_W-1:0] vy1;
        logic signed [VEL_W-1:0] vx2;
        logic signed [VEL_W-1:0] vy2;
        logic                    neg_x;
        logic                    neg_y;
        logic [NUM_W-1:0]        num_x;
        logic [NUM_W-1:0]        num_y;
        logic [DIV_W-1:0]        den;
    } qitem_t;

endpackage
`default_nettype wire

// ===== hdl/dec_front.sv =====
// Front end: radius registers, contact test and impulse numerators.
// Depends on dec_pkg; feeds dec_fifo.
`default_nettype none
module dec_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [dec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dec_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire dec_pkg::req_t                  req,
    input  wire logic [dec_pkg::CNT_W-1:0]      queue_count,
    output logic                                push,
    output dec_pkg::qitem_t                     item
);
    import dec_pkg::*;

    logic [RAD_W-1:0] disc_r_reg, ball_r_reg;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;

    logic signed [DIFF_W-1:0] s1_dx_reg, s1_dy_reg;
    logic signed [DV_W-1:0]   s1_dvx_reg, s1_dvy_reg;
    logic signed [VEL_W-1:0]  s1_v_reg [4];
    logic [RSUM_W-1:0]        s1_rsum_reg;

    logic signed [DIFF_W-1:0] s2_dx_reg, s2_dy_reg;
    logic signed [VEL_W-1:0]  s2_v_reg [4];
    logic [D2_W-1:0]          s2_d2_reg;
    logic [RSQ_W-1:0]         s2_rsq_reg;
    logic signed [DOT_W-1:0]  s2_dot_reg;

    logic                     s3_contact_reg, s3_coin_reg;
    logic signed [VEL_W-1:0]  s3_v_reg [4];
    logic signed [PROD_W-1:0] s3_px_reg, s3_py_reg;
    logic [D2_W-1:0]          s3_d2_reg;

    logic [CNT_W-1:0]         occ;
    logic accept;

    logic signed [DIFF_W-1:0] dx_c, dy_c, ndx_c, ndy_c;
    logic signed [DV_W-1:0]   dvx_c, dvy_c;
    logic [RSUM_W-1:0]        rsum_c;
    logic signed [D2_W-1:0]   sqx_c, sqy_c;
    logic signed [DV_W+DIFF_W-1:0] px_c, py_c;
    logic [PROD_W-1:0]        magx_c, magy_c;

    assign occ = queue_count + CNT_W'(s1_valid_reg) + CNT_W'(s2_valid_reg)
               + CNT_W'(s3_valid_reg);
    assign req_stall = occ >= CNT_W'(FIFO_DEPTH);
    assign accept = req_valid && !req_stall;

    assign dx_c  = $signed({1'b0, req.first_x}) - $signed({1'b0, req.second_x});
    assign dy_c  = $signed({1'b0, req.first_y}) - $signed({1'b0, req.second_y});
    assign dvx_c = DV_W'(req.first_vx) - DV_W'(req.second_vx);
    assign dvy_c = DV_W'(req.first_vy) - DV_W'(req.second_vy);
    assign rsum_c = {1'b0, disc_r_reg}
                  + {1'b0, (req.second_is_ball ? ball_r_reg : disc_r_reg)};

    assign sqx_c = s1_dx_reg * s1_dx_reg;
    assign sqy_c = s1_dy_reg * s1_dy_reg;
    assign px_c  = s1_dvx_reg * s1_dx_reg;
    assign py_c  = s1_dvy_reg * s1_dy_reg;

    assign ndx_c = -s2_dx_reg;
    assign ndy_c = -s2_dy_reg;

    assign magx_c = s3_px_reg[PROD_W-1] ? PROD_W'(-s3_px_reg) : PROD_W'(s3_px_reg);
    assign magy_c = s3_py_reg[PROD_W-1] ? PROD_W'(-s3_py_reg) : PROD_W'(s3_py_reg);

    assign push = s3_valid_reg;

    always_comb
    begin
        item.contact    = s3_contact_reg;
        item.coincident = s3_coin_reg;
        item.active     = s3_contact_reg && !s3_coin_reg;
        item.vx1        = s3_v_reg[0];
        item.vy1        = s3_v_reg[1];
        item.vx2        = s3_v_reg[2];
        item.vy2        = s3_v_reg[3];
        item.neg_x      = s3_px_reg[PROD_W-1];
        item.neg_y      = s3_py_reg[PROD_W-1];
        item.num_x      = {magx_c, 1'b0} + NUM_W'(s3_d2_reg);
        item.num_y      = {magy_c, 1'b0} + NUM_W'(s3_d2_reg);
        item.den        = DIV_W'({s3_d2_reg, 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disc_r_reg   <= DISC_RADIUS_RST;
            ball_r_reg   <= BALL_RADIUS_RST;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DISC_RADIUS: disc_r_reg <= cfg_data;
                    REG_BALL_RADIUS: ball_r_reg <= cfg_data;
                    default: ;
                endcase
            end
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dx_reg   <= dx_c;
        s1_dy_reg   <= dy_c;
        s1_dvx_reg  <= dvx_c;
        s1_dvy_reg  <= dvy_c;
        s1_rsum_reg <= rsum_c;
        s1_v_reg[0] <= req.first_vx;
        s1_v_reg[1] <= req.first_vy;
        s1_v_reg[2] <= req.second_vx;
        s1_v_reg[3] <= req.second_vy;

        s2_dx_reg  <= s1_dx_reg;
        s2_dy_reg  <= s1_dy_reg;
        s2_v_reg   <= s1_v_reg;
        s2_d2_reg  <= D2_W'($unsigned(sqx_c) + $unsigned(sqy_c));
        s2_rsq_reg <= s1_rsum_reg * s1_rsum_reg;
        s2_dot_reg <= DOT_W'(px_c) + DOT_W'(py_c);

        s3_contact_reg <= s2_d2_reg <= D2_W'(s2_rsq_reg);
        s3_coin_reg    <= s2_d2_reg == '0;
        s3_v_reg       <= s2_v_reg;
        s3_px_reg      <= s2_dot_reg * ndx_c;
        s3_py_reg      <= s2_dot_reg * ndy_c;
        s3_d2_reg      <= s2_d2_reg;
    end

endmodule
`default_nettype wire

// ===== hdl/dec_fifo.sv =====
// Request queue between front end and divider back end.
// Depends on dec_pkg and the assertion macro header.
`default_nettype none
`include "disc_elastic_collision_macros.svh"
module dec_fifo (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire dec_pkg::qitem_t            wdata,
    input  wire logic                       pop,
    output dec_pkg::qitem_t                 rdata,
    output logic [dec_pkg::CNT_W-1:0]       count,
    output logic                            avail
);
    import dec_pkg::*;

    qitem_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    assign rdata = mem_reg[rd_ptr_reg];
    assign count = count_reg;
    assign avail = count_reg != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    `DEC_ASSERT_NEVER(a_no_overflow, push && !pop && (count_reg == CNT_W'(FIFO_DEPTH)), "queue overflow")
    `DEC_ASSERT_NEVER(a_no_underflow, pop && (count_reg == '0), "queue underflow")
    `DEC_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "count lost a push")

endmodule
`default_nettype wire

// ===== hdl/dec_back.sv =====
// Back end: pipelined rounding divider, one quotient bit per stage, then saturation.
// Depends on dec_pkg; takes requests from dec_fifo.
`default_nettype none
module dec_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dec_pkg::qitem_t    item,
    input  wire logic               avail,
    output logic                    pop,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output dec_pkg::rsp_t           rsp
);
    import dec_pkg::*;

    typedef struct packed {
        logic                    contact;
        logic                    coincident;
        logic                    active;
        logic signed [VEL_W-1:0] vx1;
        logic signed [VEL_W-1:0] vy1;
        logic signed [VEL_W-1:0] vx2;
        logic signed [VEL_W-1:0] vy2;
        logic                    neg_x;
        logic                    neg_y;
        logic [REM_W-1:0]        rem_x;
        logic [REM_W-1:0]        rem_y;
        logic [Q_W-1:0]          low_x;
        logic [Q_W-1:0]          low_y;
        logic [Q_W-1:0]          quo_x;
        logic [Q_W-1:0]          quo_y;
        logic [DIV_W-1:0]        den;
    } bstage_t;

    bstage_t st_reg [Q_W+1];
    logic    vld_reg [Q_W+1];
    logic    rsp_valid_reg;
    rsp_t    rsp_reg;

    logic    advance;
    bstage_t load_c, fin_c;
    bstage_t nxt_c [Q_W];
    rsp_t    rsp_next;
    logic signed [Q_W:0] delx_c, dely_c;

    function automatic bstage_t div_step(input bstage_t s);
        bstage_t          n;
        logic [REM_W-1:0] tx, ty, dd;
        logic             gx, gy;
        n  = s;
        dd = REM_W'(s.den);
        tx = {s.rem_x[REM_W-2:0], s.low_x[Q_W-1]};
        ty = {s.rem_y[REM_W-2:0], s.low_y[Q_W-1]};
        gx = tx >= dd;
        gy = ty >= dd;
        n.rem_x = gx ? tx - dd : tx;
        n.rem_y = gy ? ty - dd : ty;
        n.low_x = {s.low_x[Q_W-2:0], 1'b0};
        n.low_y = {s.low_y[Q_W-2:0], 1'b0};
        n.quo_x = {s.quo_x[Q_W-2:0], gx};
        n.quo_y = {s.quo_y[Q_W-2:0], gy};
        return n;
    endfunction

    function automatic logic signed [VEL_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(VEL_MAX))
            return VEL_W'(VEL_MAX);
        else if (v < SUM_W'(VEL_MIN))
            return VEL_W'(VEL_MIN);
        else
            return VEL_W'(v);
    endfunction

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign pop       = advance && avail;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        load_c.contact    = item.contact;
        load_c.coincident = item.coincident;
        load_c.active     = item.active;
        load_c.vx1        = item.vx1;
        load_c.vy1        = item.vy1;
        load_c.vx2        = item.vx2;
        load_c.vy2        = item.vy2;
        load_c.neg_x      = item.neg_x;
        load_c.neg_y      = item.neg_y;
        load_c.rem_x      = REM_W'(item.num_x[NUM_W-1:Q_W]);
        load_c.rem_y      = REM_W'(item.num_y[NUM_W-1:Q_W]);
        load_c.low_x      = item.num_x[Q_W-1:0];
        load_c.low_y      = item.num_y[Q_W-1:0];
        load_c.quo_x      = '0;
        load_c.quo_y      = '0;
        load_c.den        = item.den;
    end

    always_comb
    begin
        for (int k = 0; k < Q_W; k++)
            nxt_c[k] = div_step(st_reg[k]);
    end

    always_comb
    begin
        fin_c  = st_reg[Q_W];
        delx_c = fin_c.neg_x ? -$signed({1'b0, fin_c.quo_x}) : $signed({1'b0, fin_c.quo_x});
        dely_c = fin_c.neg_y ? -$signed({1'b0, fin_c.quo_y}) : $signed({1'b0, fin_c.quo_y});
        rsp_next.contact    = fin_c.contact;
        rsp_next.coincident = fin_c.coincident;
        if (fin_c.active)
        begin
            rsp_next.new_first_vx  = sat(SUM_W'(fin_c.vx1) + SUM_W'(delx_c));
            rsp_next.new_first_vy  = sat(SUM_W'(fin_c.vy1) + SUM_W'(dely_c));
            rsp_next.new_second_vx = sat(SUM_W'(fin_c.vx2) - SUM_W'(delx_c));
            rsp_next.new_second_vy = sat(SUM_W'(fin_c.vy2) - SUM_W'(dely_c));
        end
        else
        begin
            rsp_next.new_first_vx  = fin_c.vx1;
            rsp_next.new_first_vy  = fin_c.vy1;
            rsp_next.new_second_vx = fin_c.vx2;
            rsp_next.new_second_vy = fin_c.vy2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= Q_W; k++)
                vld_reg[k] <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= avail;
            for (int k = 0; k < Q_W; k++)
                vld_reg[k+1] <= vld_reg[k];
            rsp_valid_reg <= vld_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg[0] <= load_c;
            for (int k = 0; k < Q_W; k++)
                st_reg[k+1] <= nxt_c[k];
            rsp_reg <= rsp_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/disc_elastic_collision.sv =====
// Disc collision top: front end, request queue and divider back end.
// Throughput one request per cycle while req_stall is low; the divider is an 18-stage pipeline.
// An 8-entry queue between front end and divider absorbs output stall.
// Reset is asynchronous, active low: clears all valid state, radii return to 400 and 240.
// Depends on dec_pkg, dec_front, dec_fifo, dec_back.
`default_nettype none
module disc_elastic_collision (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [dec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dec_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire dec_pkg::req_t                  req,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output dec_pkg::rsp_t                       rsp
);
    import dec_pkg::*;

    logic             push, pop, avail;
    qitem_t           wdata, rdata;
    logic [CNT_W-1:0] count;

    dec_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .queue_count (count),
        .push        (push),
        .item        (wdata)
    );

    dec_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wdata),
        .pop   (pop),
        .rdata (rdata),
        .count (count),
        .avail (avail)
    );

    dec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (rdata),
        .avail     (avail),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for disc_elastic_collision: contact test and equal-mass
// elastic response, predicted per request and compared field by field in order.
// Depends on dec_pkg and the disc_elastic_collision RTL.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dec_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    disc_elastic_collision dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    req_t pending_reqs[$];
    rsp_t expected_velocities[$];
    logic [RAD_W-1:0] disc_rad;
    logic [RAD_W-1:0] ball_rad;
    int errors;
    int sent;
    int received;
    int contacts;
    int coincidents;
    longint cycles;
    bit calm;
    bit req_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [VEL_W-1:0] clamp_vel(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[VEL_W-1:0];
    endfunction

    function automatic rsp_t predict_collision(req_t r);
        rsp_t o;
        longint dx, dy, d2, rs, dot, delx, dely;
        longint vx1, vy1, vx2, vy2;
        vx1 = r.first_vx;
        vy1 = r.first_vy;
        vx2 = r.second_vx;
        vy2 = r.second_vy;
        dx = longint'(r.first_x) - longint'(r.second_x);
        dy = longint'(r.first_y) - longint'(r.second_y);
        d2 = dx * dx + dy * dy;
        rs = longint'(disc_rad) + longint'(r.second_is_ball ? ball_rad : disc_rad);
        o.contact = (d2 <= rs * rs);
        o.coincident = (d2 == 0);
        o.new_first_vx = r.first_vx;
        o.new_first_vy = r.first_vy;
        o.new_second_vx = r.second_vx;
        o.new_second_vy = r.second_vy;
        if (o.contact && !o.coincident)
        begin
            dot = (vx1 - vx2) * dx + (vy1 - vy2) * dy;
            delx = round_div(dot * (-dx), d2);
            dely = round_div(dot * (-dy), d2);
            o.new_first_vx = clamp_vel(vx1 + delx);
            o.new_first_vy = clamp_vel(vy1 + dely);
            o.new_second_vx = clamp_vel(vx2 - delx);
            o.new_second_vy = clamp_vel(vy2 - dely);
        end
        return o;
    endfunction

    function automatic req_t random_pair(bit near);
        req_t r;
        int span;
        r.first_x = POS_W'($urandom);
        r.first_y = POS_W'($urandom);
        r.first_vx = VEL_W'($urandom);
        r.first_vy = VEL_W'($urandom);
        r.second_is_ball = 1'($urandom);
        if (near)
        begin
            span = $urandom_range(1, 0) ? 40 : 2200;
            r.second_x = POS_W'(int'(r.first_x) + int'($urandom_range(2 * span)) - span);
            r.second_y = POS_W'(int'(r.first_y) + int'($urandom_range(2 * span)) - span);
        end
        else
        begin
            r.second_x = POS_W'($urandom);
            r.second_y = POS_W'($urandom);
        end
        case ($urandom_range(5))
            0: begin
                r.second_vx = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                r.second_vy = VEL_W'($urandom);
                r.first_vx = -r.second_vx;
            end
            1: begin
                r.second_vx = VEL_W'(int'($urandom_range(64)) - 32);
                r.second_vy = VEL_W'(int'($urandom_range(64)) - 32);
            end
            default: begin
                r.second_vx = VEL_W'($urandom);
                r.second_vy = VEL_W'($urandom);
            end
        endcase
        if ($urandom_range(1) == 0)
            r.second_vy = VEL_W'($urandom);
        return r;
    endfunction

    function automatic req_t make_pair(int x1, int y1, int vx1, int vy1,
                                       int x2, int y2, int vx2, int vy2, bit ball);
        req_t r;
        r.first_x = POS_W'(x1);
        r.first_y = POS_W'(y1);
        r.first_vx = VEL_W'(vx1);
        r.first_vy = VEL_W'(vy1);
        r.second_x = POS_W'(x2);
        r.second_y = POS_W'(y2);
        r.second_vx = VEL_W'(vx2);
        r.second_vy = VEL_W'(vy2);
        r.second_is_ball = ball;
        return r;
    endfunction

    task automatic add_req(req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic write_radius(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_DISC_RADIUS)
            disc_rad = RAD_W'(value);
        else
            ball_rad = RAD_W'(value);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_velocities.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_taken)
        begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 35))
            begin
                req <= pending_reqs[0];
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 35);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        req_taken <= rst_n && req_valid && !req_stall;
        if (rst_n && req_valid && !req_stall)
        begin
            expected_velocities.insert(expected_velocities.size(), predict_collision(req));
            void'(pending_reqs.pop_front());
            sent <= sent + 1;
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_t e;
            received <= received + 1;
            if (expected_velocities.size() == 0)
            begin
                $error("unexpected result %p", rsp);
                errors <= errors + 1;
            end
            else
            begin
                e = expected_velocities.pop_front();
                contacts <= contacts + rsp.contact;
                coincidents <= coincidents + rsp.coincident;
                if (rsp.contact !== e.contact)
                    $error("contact exp %0d got %0d", e.contact, rsp.contact);
                if (rsp.coincident !== e.coincident)
                    $error("coincident exp %0d got %0d", e.coincident, rsp.coincident);
                if (rsp.new_first_vx !== e.new_first_vx)
                    $error("new_first_vx exp %0d got %0d", e.new_first_vx, rsp.new_first_vx);
                if (rsp.new_first_vy !== e.new_first_vy)
                    $error("new_first_vy exp %0d got %0d", e.new_first_vy, rsp.new_first_vy);
                if (rsp.new_second_vx !== e.new_second_vx)
                    $error("new_second_vx exp %0d got %0d", e.new_second_vx,
                           rsp.new_second_vx);
                if (rsp.new_second_vy !== e.new_second_vy)
                    $error("new_second_vy exp %0d got %0d", e.new_second_vy,
                           rsp.new_second_vy);
                if (rsp !== e)
                    errors <= errors + 1;
            end
        end
        if (cycles > 400000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int radii[6][2];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        errors = 0;
        sent = 0;
        received = 0;
        contacts = 0;
        coincidents = 0;
        cycles = 0;
        calm = 1'b0;
        req_taken = 1'b0;
        disc_rad = DISC_RADIUS_RST;
        ball_rad = BALL_RADIUS_RST;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_req(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_req(make_pair(16383, 16383, -32768, 32767, 16383, 16383, 32767, -32768, 1));
        add_req(make_pair(0, 0, 32767, 32767, 16383, 16383, -32768, -32768, 0));
        add_req(make_pair(1000, 1000, 256, 0, 1800, 1000, -256, 0, 0));
        add_req(make_pair(1000, 1000, 256, 0, 1801, 1000, -256, 0, 0));
        add_req(make_pair(1000, 1000, 256, 0, 1640, 1000, -256, 0, 1));
        add_req(make_pair(1000, 1000, 256, 0, 1641, 1000, -256, 0, 1));
        add_req(make_pair(5000, 5000, 32767, 32767, 5001, 5001, -32768, -32768, 0));
        add_req(make_pair(5000, 5000, -32768, 0, 5001, 5000, 32767, 0, 1));
        add_req(make_pair(3000, 3000, 100, -300, 3300, 3400, 5, 7, 0));
        add_req(make_pair(3000, 3000, 1, 0, 3003, 3000, 0, 0, 0));
        add_req(make_pair(3000, 3000, -1, 0, 3003, 3000, 0, 0, 0));
        drain();

        radii = '{'{0, 0}, '{1023, 1023}, '{0, 1023}, '{1023, 0}, '{17, 600}, '{400, 240}};
        for (phase = 0; phase < 6; phase++)
        begin
            write_radius(REG_DISC_RADIUS, radii[phase][0]);
            write_radius(REG_BALL_RADIUS, radii[phase][1]);
            if (phase < 2)
            begin
                add_req(make_pair(7000, 7000, 300, 300, 7000, 7000, 9, 9, 0));
                add_req(make_pair(7000, 7000, 300, 300, 7001, 7000, 9, 9, 1));
                add_req(make_pair(7000, 7000, 300, 300, 9046, 7000, 9, 9, 0));
                add_req(make_pair(7000, 7000, 300, 300, 9047, 7000, 9, 9, 0));
            end
            calm = (phase == 3);
            repeat (200)
                add_req(random_pair($urandom_range(99) < 80));
            drain();
        end

        $display("Covered %0d requests, %0d results over six radius settings;", sent, received);
        $display("%0d contacts, %0d with coincident centres.", contacts, coincidents);
        if (errors == 0 && expected_velocities.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/dec_pkg.sv
hdl/dec_front.sv
hdl/dec_fifo.sv
hdl/dec_back.sv
hdl/disc_elastic_collision.sv
test/testbench.sv
